// ===== rtl/mwsm_pkg.sv =====
// Shared types, widths and constants for the mecanum wheel speed mixer.
package mwsm_pkg;

	// Field widths
	localparam int IN_W      = 24;
	localparam int SPEED_W   = 16;
	localparam int LEVER_W   = 16;
	localparam int GAIN_W    = 24;
	localparam int LIMIT_W   = 15;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// Saturation width of the motor targets, clamped to the 16-bit field
	localparam int MOTOR_SPEED_BITS = 16;
	localparam int SAT_BITS = (MOTOR_SPEED_BITS > SPEED_W) ? SPEED_W :
		((MOTOR_SPEED_BITS < 2) ? 2 : MOTOR_SPEED_BITS);

	// Datapath widths
	localparam int NWHEEL  = 4;
	localparam int WIDX_W  = 2;
	localparam int WHEEL_W = 41;                  // signed wheel speed, Q.16
	localparam int UW_W    = WHEEL_W - 1;         // wheel magnitude
	localparam int LO_W    = 16;                  // low split of the magnitude
	localparam int HI_W    = UW_W - LO_W;
	localparam int MAG_W   = 32;                  // motor magnitude in rpm
	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 24;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int NUM_W   = MAG_W + LIMIT_W;     // scaling dividend
	localparam int QUOT_W  = LIMIT_W;             // scaled magnitude never exceeds limit
	localparam int DIV_CNT_W = $clog2(QUOT_W + 1); // divider step counter

	// Saturation bounds
	localparam logic [MAG_W:0] SAT_POS = (MAG_W+1)'((64'd1 << (SAT_BITS - 1)) - 64'd1);
	localparam logic [MAG_W:0] SAT_NEG = SAT_POS + (MAG_W+1)'(1);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TURN_LEVER_ARM      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_TO_MOTOR_GAIN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MOTOR_SPEED_LIMIT   = 2'd2;

	// Register reset values
	localparam logic [LEVER_W-1:0] LEVER_RST = 16'd6400;
	localparam logic [GAIN_W-1:0]  GAIN_RST  = 24'd65536;
	localparam logic [LIMIT_W-1:0] LIMIT_RST = 15'd8000;

	// Action codes
	localparam logic ACT_STOP = 1'b0;
	localparam logic ACT_SET  = 1'b1;

	// Motors one and three are mounted reversed (bit i is wheel i)
	localparam logic [NWHEEL-1:0] MOUNT_REV = 4'b0101;

	typedef struct packed {
		logic signed [IN_W-1:0] forward_speed;
		logic signed [IN_W-1:0] sideways_speed;
		logic signed [IN_W-1:0] turn_rate;
	} cmd_t;

	typedef struct packed {
		logic                      action;
		logic signed [SPEED_W-1:0] motor_one_speed;
		logic signed [SPEED_W-1:0] motor_two_speed;
		logic signed [SPEED_W-1:0] motor_three_speed;
		logic signed [SPEED_W-1:0] motor_four_speed;
	} mix_t;

endpackage

// ===== rtl/mwsm_mul.sv =====
// Shared unsigned multiplier with a registered product.
module mwsm_mul (
	input  logic                         clk,
	input  logic                         en,
	input  logic [mwsm_pkg::MUL_A_W-1:0] a,
	input  logic [mwsm_pkg::MUL_B_W-1:0] b,
	output logic [mwsm_pkg::PROD_W-1:0]  prod
);
	import mwsm_pkg::*;

	logic [PROD_W-1:0] prod_q;

	// Capture one product per issue
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= PROD_W'(a) * PROD_W'(b);
		end
	end

	assign prod = prod_q;

endmodule

// ===== rtl/mwsm_div.sv =====
// Restoring divider, one quotient bit per cycle, for limit scaling.
module mwsm_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [mwsm_pkg::NUM_W-1:0]  num,
	input  logic [mwsm_pkg::MAG_W-1:0]  den,
	output logic                        done,
	output logic [mwsm_pkg::QUOT_W-1:0] quot
);
	import mwsm_pkg::*;

	logic [MAG_W-1:0]     rem_q;
	logic [MAG_W-1:0]     den_q;
	logic [QUOT_W-1:0]    bits_q;     // dividend low bits in, quotient bits out
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [MAG_W+1:0]     diff;
	logic                 take;

	// Trial subtract of the shifted remainder
	assign diff = {1'b0, rem_q, bits_q[QUOT_W-1]} - {2'b00, den_q};
	assign take = ~diff[MAG_W+1];

	// Control: count quotient bits and flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(QUOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the high dividend part is already below the divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num[NUM_W-1:QUOT_W];
			bits_q <= num[QUOT_W-1:0];
			den_q  <= den;
		end else if (busy_q) begin
			rem_q  <= take ? diff[MAG_W-1:0] : {rem_q[MAG_W-2:0], bits_q[QUOT_W-1]};
			bits_q <= {bits_q[QUOT_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quot = bits_q;

endmodule

// ===== rtl/mecanum_wheel_speed_mixer.sv =====
// Top level: registers, sequencer and output stage of the mecanum wheel speed mixer.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+--------------------------------
//  cmd     | in        | cmd_valid / cmd_stall  | forward, sideways, turn speeds
//  mix     | out       | mix_valid / mix_stall  | action and four motor speeds
//  cfg     | in        | cfg_we                 | cfg_index, cfg_data
//
// A moving command is mixed wheel by wheel through the shared multiplier; when the
// limit scaling runs, it adds one multiply plus a 15-step divide per wheel.
// A stop command goes straight to the output stage; a repeated zero command gives nothing.
// The multiplier is shared between all steps and the divider is bit-serial.
// cmd_stall is high while a command is in work; a stalled result sits in the
// output register while the next command is taken. Reset loads the register defaults.
module mecanum_wheel_speed_mixer (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cmd_valid,
	output logic                           cmd_stall,
	input  mwsm_pkg::cmd_t                 cmd,
	output logic                           mix_valid,
	input  logic                           mix_stall,
	output mwsm_pkg::mix_t                 mix,
	input  logic                           cfg_we,
	input  logic [mwsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mwsm_pkg::CFG_W-1:0]     cfg_data
);
	import mwsm_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_TURN  = 11'b000_0000_0010,
		S_TLAT  = 11'b000_0000_0100,
		S_WSUM  = 11'b000_0000_1000,
		S_LO    = 11'b000_0001_0000,
		S_HI    = 11'b000_0010_0000,
		S_ACC   = 11'b000_0100_0000,
		S_CHK   = 11'b000_1000_0000,
		S_SMUL  = 11'b001_0000_0000,
		S_SWAIT = 11'b010_0000_0000,
		S_OUT   = 11'b100_0000_0000
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [LEVER_W-1:0] lever_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [LIMIT_W-1:0] limit_q;

	// Command and work registers
	logic                      stopped_q;
	logic                      stop_q;
	logic signed [IN_W-1:0]    x_q;
	logic signed [IN_W-1:0]    y_q;
	logic [IN_W-1:0]           r_mag_q;
	logic                      r_neg_q;
	logic signed [WHEEL_W-1:0] t_q;
	logic [UW_W-1:0]           uw_q;
	logic                      wneg_q;
	logic [MUL_B_W-1:0]        lo_q;
	logic [WIDX_W-1:0]         idx_q;
	logic [MAG_W-1:0]          mag_q [NWHEEL];
	logic [NWHEEL-1:0]         neg_q;
	logic [MAG_W-1:0]          max_q;
	logic                      div_start_q;

	// Output register
	logic mix_valid_q;
	mix_t mix_q;

	// Shared unit wiring
	logic               mul_en;
	logic [MUL_A_W-1:0] mul_a;
	logic [MUL_B_W-1:0] mul_b;
	logic [PROD_W-1:0]  prod;
	logic               div_done;
	logic [QUOT_W-1:0]  quot;

	// Combinational helpers
	logic                      cmd_take;
	logic                      cmd_zero;
	logic                      out_free;
	logic signed [WHEEL_W-1:0] xs;
	logic signed [WHEEL_W-1:0] ys;
	logic signed [WHEEL_W-1:0] wheel;
	logic signed [WHEEL_W-1:0] wheel_neg;
	logic [MAG_W:0]            part;
	logic [MAG_W-1:0]          mag_new;

	// Clamp a magnitude with its sign to the signed motor range
	function automatic logic signed [SPEED_W-1:0] sat_speed(
		input logic [MAG_W-1:0] m,
		input logic             n
	);
		logic [MAG_W:0] lim;
		logic [MAG_W:0] mm;
		lim = n ? SAT_NEG : SAT_POS;
		mm  = ({1'b0, m} > lim) ? lim : {1'b0, m};
		if (n) begin
			mm = -mm;
		end
		return mm[SPEED_W-1:0];
	endfunction

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_take  = cmd_valid && !cmd_stall;
	assign cmd_zero  = (cmd.forward_speed == '0) && (cmd.sideways_speed == '0) &&
		(cmd.turn_rate == '0);
	assign out_free  = !mix_valid_q || !mix_stall;

	// Wheel sum: t added on wheels one and three, y added on wheels two and three
	assign xs = {{(WHEEL_W-IN_W-8){x_q[IN_W-1]}}, x_q, 8'b0};
	assign ys = {{(WHEEL_W-IN_W-8){y_q[IN_W-1]}}, y_q, 8'b0};
	assign wheel = xs + ((idx_q[0] ^ idx_q[1]) ? ys : -ys) + (idx_q[0] ? -t_q : t_q);
	assign wheel_neg = -wheel;

	// Recombine the split product: (hi*g + (lo*g >> 16)) >> 16
	assign part    = (MAG_W+1)'((prod[MUL_B_W+HI_W-1:0] + (MUL_B_W+HI_W)'(lo_q)) >> LO_W);
	assign mag_new = part[MAG_W-1:0];

	// Operand select for the shared multiplier
	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		case (state_q)
			S_TURN: begin
				mul_a = MUL_A_W'(r_mag_q);
				mul_b = MUL_B_W'(lever_q);
			end
			S_LO: begin
				mul_a = MUL_A_W'(uw_q[LO_W-1:0]);
				mul_b = gain_q;
			end
			S_HI: begin
				mul_a = MUL_A_W'(uw_q[UW_W-1:LO_W]);
				mul_b = gain_q;
			end
			S_SMUL: begin
				mul_a = mag_q[idx_q];
				mul_b = MUL_B_W'(limit_q);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	mwsm_mul u_mul (
		.clk  (clk),
		.en   (mul_en),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	mwsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.num    (prod[NUM_W-1:0]),
		.den    (max_q),
		.done   (div_done),
		.quot   (quot)
	);

	// Configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lever_q <= LEVER_RST;
			gain_q  <= GAIN_RST;
			limit_q <= LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TURN_LEVER_ARM:      lever_q <= cfg_data[LEVER_W-1:0];
				REG_SPEED_TO_MOTOR_GAIN: gain_q  <= cfg_data[GAIN_W-1:0];
				REG_MOTOR_SPEED_LIMIT:   limit_q <= cfg_data[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			stopped_q   <= 1'b0;
			idx_q       <= '0;
			div_start_q <= 1'b0;
			mix_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (mix_valid_q && !mix_stall) begin
				mix_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_take) begin
						idx_q <= '0;
						if (cmd_zero) begin
							if (!stopped_q) begin
								stopped_q <= 1'b1;
								state_q   <= S_OUT;
							end
						end else begin
							stopped_q <= 1'b0;
							state_q   <= S_TURN;
						end
					end
				end
				S_TURN:  state_q <= S_TLAT;
				S_TLAT:  state_q <= S_WSUM;
				S_WSUM:  state_q <= S_LO;
				S_LO:    state_q <= S_HI;
				S_HI:    state_q <= S_ACC;
				S_ACC: begin
					idx_q <= idx_q + WIDX_W'(1);
					state_q <= (idx_q == WIDX_W'(NWHEEL - 1)) ? S_CHK : S_WSUM;
				end
				S_CHK: begin
					idx_q <= '0;
					state_q <= (max_q > MAG_W'(limit_q)) ? S_SMUL : S_OUT;
				end
				S_SMUL: begin
					div_start_q <= 1'b1;
					state_q     <= S_SWAIT;
				end
				S_SWAIT: begin
					if (div_done) begin
						idx_q <= idx_q + WIDX_W'(1);
						state_q <= (idx_q == WIDX_W'(NWHEEL - 1)) ? S_OUT : S_SMUL;
					end
				end
				S_OUT: begin
					if (out_free) begin
						mix_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd_take) begin
					stop_q  <= cmd_zero;
					x_q     <= cmd.forward_speed;
					y_q     <= cmd.sideways_speed;
					r_neg_q <= cmd.turn_rate[IN_W-1];
					r_mag_q <= cmd.turn_rate[IN_W-1] ? -cmd.turn_rate : cmd.turn_rate;
					max_q   <= '0;
				end
			end
			S_TLAT: begin
				t_q <= r_neg_q ? -{1'b0, prod[UW_W-1:0]} : {1'b0, prod[UW_W-1:0]};
			end
			S_WSUM: begin
				wneg_q <= wheel[WHEEL_W-1];
				uw_q   <= wheel[WHEEL_W-1] ? wheel_neg[UW_W-1:0] : wheel[UW_W-1:0];
			end
			S_HI: begin
				lo_q <= prod[LO_W+MUL_B_W-1:LO_W];
			end
			S_ACC: begin
				mag_q[idx_q] <= mag_new;
				neg_q[idx_q] <= (mag_new != '0) && (wneg_q ^ MOUNT_REV[idx_q]);
				if (mag_new > max_q) begin
					max_q <= mag_new;
				end
			end
			S_SWAIT: begin
				if (div_done) begin
					mag_q[idx_q] <= MAG_W'(quot);
				end
			end
			S_OUT: begin
				if (out_free) begin
					if (stop_q) begin
						mix_q <= '{action: ACT_STOP, default: '0};
					end else begin
						mix_q.action            <= ACT_SET;
						mix_q.motor_one_speed   <= sat_speed(mag_q[0], neg_q[0]);
						mix_q.motor_two_speed   <= sat_speed(mag_q[1], neg_q[1]);
						mix_q.motor_three_speed <= sat_speed(mag_q[2], neg_q[2]);
						mix_q.motor_four_speed  <= sat_speed(mag_q[3], neg_q[3]);
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign mix_valid = mix_valid_q;
	assign mix       = mix_q;

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the mecanum wheel speed mixer: directed rows, then random phases.
`timescale 1ns / 1ps

module testbench;
	import mwsm_pkg::*;

	localparam int NUM_DIRECTED   = 20;
	localparam int NUM_PHASES     = 9;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int SETTLE_CYCLES  = 120;
	localparam int WATCHDOG_LIMIT = 4000;

	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam logic [SPEED_W-1:0] RPM_POS_LIMIT = 16'd8000;
	localparam logic [SPEED_W-1:0] RPM_NEG_LIMIT = -16'sd8000;

	typedef struct packed {
		cmd_t cmd;
		logic typed;
		logic yields;
		mix_t result;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cmd_valid;
	logic                 cmd_stall;
	cmd_t                 cmd;
	logic                 mix_valid;
	logic                 mix_stall;
	mix_t                 mix;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	// Predictor copy of the registers and the stop state
	logic [LEVER_W-1:0] lever_arm;
	logic [GAIN_W-1:0]  motor_gain;
	logic [LIMIT_W-1:0] speed_limit;
	bit                 is_stopped;

	mix_t pending_mix [$];
	int   mismatch_count;
	int   quiet_cycles;
	int   tx_idle_pct;
	int   rx_idle_pct;

	mecanum_wheel_speed_mixer u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.mix_valid (mix_valid),
		.mix_stall (mix_stall),
		.mix       (mix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Mix one command into four motor targets; returns 0 when no result is due
	function automatic bit mix_wheels(input cmd_t c, output mix_t m);
		longint      xs;
		longint      ys;
		longint      tw;
		longint      wheel [NWHEEL];
		logic [63:0] mag [NWHEEL];
		bit          neg [NWHEEL];
		logic [63:0] peak;
		logic [63:0] u;
		logic [65:0] prod;
		logic [63:0] clamp;
		logic [SPEED_W-1:0] spd [NWHEEL];
		m = '0;
		if (c.forward_speed == '0 && c.sideways_speed == '0 && c.turn_rate == '0) begin
			if (is_stopped)
				return 1'b0;
			is_stopped = 1'b1;
			m.action = ACT_STOP;
			return 1'b1;
		end
		is_stopped = 1'b0;
		xs = longint'(c.forward_speed) * 256;
		ys = longint'(c.sideways_speed) * 256;
		tw = longint'(c.turn_rate) * longint'(lever_arm);
		wheel[0] = xs - ys + tw;
		wheel[1] = xs + ys - tw;
		wheel[2] = xs + ys + tw;
		wheel[3] = xs - ys - tw;
		peak = '0;
		for (int i = 0; i < NWHEEL; i++) begin
			u = (wheel[i] < 0) ? 64'(-wheel[i]) : 64'(wheel[i]);
			prod = u * motor_gain;
			mag[i] = 64'(prod >> 32);
			neg[i] = MOUNT_REV[i] ? !(wheel[i] < 0) : (wheel[i] < 0);
			if (mag[i] == 0)
				neg[i] = 1'b0;
			if (mag[i] > peak)
				peak = mag[i];
		end
		// Scale all four down when the largest exceeds the limit
		if (peak > 64'(speed_limit)) begin
			for (int i = 0; i < NWHEEL; i++)
				mag[i] = mag[i] * 64'(speed_limit) / peak;
		end
		for (int i = 0; i < NWHEEL; i++) begin
			if (neg[i]) begin
				clamp = (mag[i] > 64'(SAT_NEG)) ? 64'(SAT_NEG) : mag[i];
				spd[i] = -clamp[SPEED_W-1:0];
			end else begin
				clamp = (mag[i] > 64'(SAT_POS)) ? 64'(SAT_POS) : mag[i];
				spd[i] = clamp[SPEED_W-1:0];
			end
		end
		m.action = ACT_SET;
		m.motor_one_speed = spd[0];
		m.motor_two_speed = spd[1];
		m.motor_three_speed = spd[2];
		m.motor_four_speed = spd[3];
		return 1'b1;
	endfunction

	// Directed stimulus table; typed rows carry the result read straight off the spec
	function automatic row_t directed_row(input int k);
		row_t row;
		row = '0;
		case (k)
			0, 4, 16: begin
				row.typed = 1'b1;
				row.yields = 1'b1;
				row.result.action = ACT_STOP;
			end
			1, 17: row.typed = 1'b1;
			2: begin
				row.cmd = {24'h7FFFFF, 24'h000000, 24'h000000};
				row.typed = 1'b1;
				row.yields = 1'b1;
				row.result = {ACT_SET, RPM_NEG_LIMIT, RPM_POS_LIMIT, RPM_NEG_LIMIT, RPM_POS_LIMIT};
			end
			3: begin
				row.cmd = {24'h800000, 24'h000000, 24'h000000};
				row.typed = 1'b1;
				row.yields = 1'b1;
				row.result = {ACT_SET, RPM_POS_LIMIT, RPM_NEG_LIMIT, RPM_POS_LIMIT, RPM_NEG_LIMIT};
			end
			5: begin
				row.cmd = {24'h000001, 24'h000000, 24'h000000};
				row.typed = 1'b1;
				row.yields = 1'b1;
				row.result = {ACT_SET, 64'd0};
			end
			6:  row.cmd = {24'h000000, 24'h7FFFFF, 24'h000000};
			7:  row.cmd = {24'h000000, 24'h800000, 24'h000000};
			8:  row.cmd = {24'h000000, 24'h000000, 24'h7FFFFF};
			9:  row.cmd = {24'h000000, 24'h000000, 24'h800000};
			10: row.cmd = {24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF};
			11: row.cmd = {24'h800000, 24'h800000, 24'h800000};
			12: row.cmd = {24'h7FFFFF, 24'h800000, 24'h7FFFFF};
			13: row.cmd = {24'hFFFFFF, 24'h000001, 24'hFFFFFF};
			14: row.cmd = {24'h000100, 24'h000000, 24'h000000};
			15: row.cmd = {24'h000000, 24'h000000, 24'h000001};
			18: row.cmd = {24'h1F4000, 24'h000000, 24'h000000};
			default: row.cmd = {24'h1F4100, 24'hFFFF00, 24'h000080};
		endcase
		return row;
	endfunction

	// Pick one speed field: zero, extremes, small values or full range
	function automatic logic [IN_W-1:0] pick_speed();
		case ($urandom_range(9))
			0: return '0;
			1: return 24'h7FFFFF;
			2: return 24'h800000;
			3, 4, 5: return 24'($urandom_range(8191)) - 24'd4096;
			default: return 24'($urandom);
		endcase
	endfunction

	task automatic check_field(input string label, input logic [SPEED_W-1:0] want,
			input logic [SPEED_W-1:0] got);
		if (got !== want) begin
			mismatch_count++;
			$display("%0t %s: expected %0d, actual %0d", $time, label,
				$signed(want), $signed(got));
		end
	endtask

	// Present one command, hold it until the transfer, then record what it should produce
	task automatic send_command(input cmd_t c, input logic typed, input logic yields,
			input mix_t typed_result);
		mix_t predicted;
		bit   has_result;
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= c;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		has_result = mix_wheels(c, predicted);
		if (typed) begin
			if (yields)
				pending_mix.push_back(typed_result);
		end else if (has_result) begin
			pending_mix.push_back(predicted);
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_TURN_LEVER_ARM:      lever_arm = data[LEVER_W-1:0];
			REG_SPEED_TO_MOTOR_GAIN: motor_gain = data[GAIN_W-1:0];
			REG_MOTOR_SPEED_LIMIT:   speed_limit = data[LIMIT_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Drain every expected result, then let a silent command finish
	task automatic settle();
		@(negedge clk);
		cmd_valid <= 1'b0;
		while (pending_mix.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_setting(input int phase);
		case (phase)
			0: begin
				write_reg(REG_TURN_LEVER_ARM, {8'hC3, LEVER_RST});
				write_reg(REG_SPEED_TO_MOTOR_GAIN, GAIN_RST);
				write_reg(REG_MOTOR_SPEED_LIMIT, {9'h1A5, LIMIT_RST});
				write_reg(REG_UNUSED, 24'hFFFFFF);
			end
			1: begin
				write_reg(REG_TURN_LEVER_ARM, 24'h000000);
				write_reg(REG_SPEED_TO_MOTOR_GAIN, 24'hFFFFFF);
				write_reg(REG_MOTOR_SPEED_LIMIT, 24'h007FFF);
			end
			2: begin
				write_reg(REG_TURN_LEVER_ARM, 24'h00FFFF);
				write_reg(REG_SPEED_TO_MOTOR_GAIN, 24'h000000);
				write_reg(REG_MOTOR_SPEED_LIMIT, 24'h000000);
			end
			3: begin
				write_reg(REG_TURN_LEVER_ARM, 24'h00FFFF);
				write_reg(REG_SPEED_TO_MOTOR_GAIN, 24'h000001);
				write_reg(REG_MOTOR_SPEED_LIMIT, 24'h000001);
			end
			4: begin
				write_reg(REG_TURN_LEVER_ARM, 24'($urandom));
				write_reg(REG_SPEED_TO_MOTOR_GAIN, 24'($urandom_range(262143)));
				write_reg(REG_MOTOR_SPEED_LIMIT, 24'($urandom_range(32767)));
			end
			5: begin
				write_reg(REG_TURN_LEVER_ARM, 24'($urandom));
				write_reg(REG_SPEED_TO_MOTOR_GAIN, GAIN_RST);
				write_reg(REG_MOTOR_SPEED_LIMIT, 24'h000000);
			end
			7: begin
				write_reg(REG_TURN_LEVER_ARM, 24'h000100);
				write_reg(REG_SPEED_TO_MOTOR_GAIN, 24'h010000);
				write_reg(REG_MOTOR_SPEED_LIMIT, 24'h007FFF);
			end
			default: begin
				write_reg(REG_TURN_LEVER_ARM, 24'($urandom));
				write_reg(REG_SPEED_TO_MOTOR_GAIN, 24'($urandom));
				write_reg(REG_MOTOR_SPEED_LIMIT, 24'($urandom));
				write_reg(REG_UNUSED, 24'($urandom));
			end
		endcase
	endtask

	// Receiver stall, redrawn every cycle
	always @(negedge clk) begin
		mix_stall <= ($urandom_range(99) < rx_idle_pct);
	end

	// Count cycles in which neither channel transfers
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (mix_valid && !mix_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin : result_check
		mix_t want;
		if (arst_n && mix_valid && !mix_stall) begin
			if (pending_mix.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected result: expected none, actual %h", $time, mix);
			end else begin
				want = pending_mix.pop_front();
				check_field("action", SPEED_W'(want.action), SPEED_W'(mix.action));
				check_field("motor_one_speed", want.motor_one_speed, mix.motor_one_speed);
				check_field("motor_two_speed", want.motor_two_speed, mix.motor_two_speed);
				check_field("motor_three_speed", want.motor_three_speed,
					mix.motor_three_speed);
				check_field("motor_four_speed", want.motor_four_speed, mix.motor_four_speed);
			end
		end
	end

	initial begin : watchdog
		while (quiet_cycles < WATCHDOG_LIMIT)
			@(posedge clk);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		row_t row;
		cmd_t c;
		clk = 1'b0;
		arst_n = 1'b0;
		cmd_valid = 1'b0;
		cmd = '0;
		mix_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatch_count = 0;
		quiet_cycles = 0;
		tx_idle_pct = 26;
		rx_idle_pct = 68;
		lever_arm = LEVER_RST;
		motor_gain = GAIN_RST;
		speed_limit = LIMIT_RST;
		is_stopped = 1'b0;

		// Hold reset, then release away from the rising edge
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed rows at the reset register values
		for (int k = 0; k < NUM_DIRECTED; k++) begin
			row = directed_row(k);
			send_command(row.cmd, row.typed, row.yields, row.result);
		end

		// Random phases, each under its own register setting and idle mix
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			settle();
			apply_setting(phase);
			tx_idle_pct = (phase < 3) ? 26 : ((phase < 6) ? 68 : 0);
			rx_idle_pct = (phase < 3) ? 68 : ((phase < 6) ? 26 : 0);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(9) == 0)
					c = '0;
				else
					c = {pick_speed(), pick_speed(), pick_speed()};
				send_command(c, 1'b0, 1'b0, '0);
			end
		end

		settle();
		if (mismatch_count == 0 && pending_mix.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== mecanum_wheel_speed_mixer.f =====
rtl/mwsm_pkg.sv
rtl/mwsm_mul.sv
rtl/mwsm_div.sv
rtl/mecanum_wheel_speed_mixer.sv
test/testbench.sv
